[sv/sla_pkg.sv]
// Shared types, constants and command codes for the status LED animation engine.
package sla_pkg;

    // Default tick width in bits
    localparam int TICK_WIDTH_DEF = 32;

    // Product width for the short divisions (9 x 16 bits)
    localparam int PROD_W = 25;
    localparam int DEN_W  = 16;

    // Mode codes
    localparam int MODE_W = 3;
    localparam logic [MODE_W-1:0] MODE_OFF     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BREATHE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FULL    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FAULT   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_STATIC  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_FADEOUT = 3'd5;

    // Register indexes on the configuration port
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_BREATH_PERIOD = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BREATH_DROP   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BREATH_MIN    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MORPH_DUR     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FADE_DUR      = 3'd4;

    // Register reset values
    localparam logic [15:0] RST_BREATH_PERIOD = 16'd2000;
    localparam logic [8:0]  RST_BREATH_DROP   = 9'd30;
    localparam logic [7:0]  RST_BREATH_MIN    = 8'd40;
    localparam logic [15:0] RST_MORPH_DUR     = 16'd1000;
    localparam logic [15:0] RST_FADE_DUR      = 16'd500;

    // Animation constants
    localparam logic [8:0]  MORPH_HUE    = 9'd120;
    localparam logic [7:0]  FULL_VALUE   = 8'd255;
    localparam logic [15:0] MIN_PERIOD   = 16'd2;

    // 250 ms blink: t / 250 = ((t >> 1) * BLINK_RECIP) >> BLINK_SHIFT, exact for 32-bit t
    localparam logic [31:0] BLINK_RECIP = 32'd2199023256;
    localparam int          BLINK_SHIFT = 38;

    // Division selects
    localparam int DSEL_W = 3;
    localparam logic [DSEL_W-1:0] DIV_NONE  = 3'd0;
    localparam logic [DSEL_W-1:0] DIV_PHASE = 3'd2;
    localparam logic [DSEL_W-1:0] DIV_BVAL  = 3'd3;
    localparam logic [DSEL_W-1:0] DIV_BDROP = 3'd4;
    localparam logic [DSEL_W-1:0] DIV_MHUE  = 3'd5;
    localparam logic [DSEL_W-1:0] DIV_MVAL  = 3'd6;
    localparam logic [DSEL_W-1:0] DIV_FVAL  = 3'd7;

    // State update selects
    localparam int USEL_W = 4;
    localparam logic [USEL_W-1:0] UPD_NONE   = 4'd0;
    localparam logic [USEL_W-1:0] UPD_OFF    = 4'd1;
    localparam logic [USEL_W-1:0] UPD_STATIC = 4'd2;
    localparam logic [USEL_W-1:0] UPD_FAULT  = 4'd3;
    localparam logic [USEL_W-1:0] UPD_TRI    = 4'd4;
    localparam logic [USEL_W-1:0] UPD_BVAL   = 4'd5;
    localparam logic [USEL_W-1:0] UPD_BDROP  = 4'd6;
    localparam logic [USEL_W-1:0] UPD_MHUE   = 4'd7;
    localparam logic [USEL_W-1:0] UPD_MVAL   = 4'd8;
    localparam logic [USEL_W-1:0] UPD_MDONE  = 4'd9;
    localparam logic [USEL_W-1:0] UPD_FVAL   = 4'd10;
    localparam logic [USEL_W-1:0] UPD_FDONE  = 4'd11;

    // Configuration register values
    typedef struct packed {
        logic [15:0] period_ms;
        logic [8:0]  hue_drop;
        logic [7:0]  min_value;
        logic [15:0] morph_ms;
        logic [15:0] fade_ms;
    } sla_cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic              load;
        logic              div_start;
        logic [DSEL_W-1:0] div_sel;
        logic [USEL_W-1:0] upd_sel;
        logic              out_load;
    } sla_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              div_done;
        logic              morph_over;
        logic              fade_over;
    } sla_stat_t;

endpackage

[sv/status_led_animation_engine.sv]
// Top level: configuration registers, stream ports and output register.
//
//   Port group   Direction  Word contents
//   s_t*         in         frame tick: time, requested mode, hue and value
//   m_t*         out        shown hue, shown value, busy and dark flags
//   APB          in/out     five configuration registers in 32-bit words at 0x00..0x10
//
// One frame word at a time. Off, static, fault, unknown modes and a finished morph
// or fade need no division; a running fade runs one, a running morph two and breathe
// three divisions on the bit-per-cycle divider, the first over DIV_W = max(TICK_WIDTH, 25) bits.
// Reset is asynchronous, active low, and restores mode off and register defaults.
// A result waits in the output register; the next word is taken as soon as the
// sequencer is idle, and only the final hand-over stalls on m_tready.
module status_led_animation_engine #(
    parameter int TICK_WIDTH = sla_pkg::TICK_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // tick_ms[31:0], req_mode[34:32], req_hue[43:35], req_value[51:44]
    input  logic [55:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // shown_hue[8:0], shown_value[16:9], busy_res[17], dark[18]
    output logic [23:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    sla_pkg::sla_cfg_t  cfg_reg, cfg_next;
    sla_pkg::sla_cmd_t  cmd;
    sla_pkg::sla_stat_t stat;

    logic [sla_pkg::REG_IDX_W-1:0] reg_idx;
    logic                          cfg_wr;

    logic        out_valid_reg, out_valid_next;
    logic [23:0] out_data_reg, out_data_next;
    logic        out_free;

    logic [8:0]  res_hue;
    logic [7:0]  res_value;
    logic        res_busy;
    logic        res_dark;

    // Configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (reg_idx)
                sla_pkg::REG_BREATH_PERIOD: cfg_next.period_ms = pwdata[15:0];
                sla_pkg::REG_BREATH_DROP:   cfg_next.hue_drop  = pwdata[8:0];
                sla_pkg::REG_BREATH_MIN:    cfg_next.min_value = pwdata[7:0];
                sla_pkg::REG_MORPH_DUR:     cfg_next.morph_ms  = pwdata[15:0];
                sla_pkg::REG_FADE_DUR:      cfg_next.fade_ms   = pwdata[15:0];
                default:                    cfg_next           = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            sla_pkg::REG_BREATH_PERIOD: prdata = 32'(cfg_reg.period_ms);
            sla_pkg::REG_BREATH_DROP:   prdata = 32'(cfg_reg.hue_drop);
            sla_pkg::REG_BREATH_MIN:    prdata = 32'(cfg_reg.min_value);
            sla_pkg::REG_MORPH_DUR:     prdata = 32'(cfg_reg.morph_ms);
            sla_pkg::REG_FADE_DUR:      prdata = 32'(cfg_reg.fade_ms);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period_ms <= sla_pkg::RST_BREATH_PERIOD;
            cfg_reg.hue_drop  <= sla_pkg::RST_BREATH_DROP;
            cfg_reg.min_value <= sla_pkg::RST_BREATH_MIN;
            cfg_reg.morph_ms  <= sla_pkg::RST_MORPH_DUR;
            cfg_reg.fade_ms   <= sla_pkg::RST_FADE_DUR;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Sequencer and datapath
    sla_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .stat     (stat),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    sla_datapath #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg       (cfg_reg),
        .in_tick   (s_tdata[31:0]),
        .in_mode   (s_tdata[34:32]),
        .in_hue    (s_tdata[43:35]),
        .in_value  (s_tdata[51:44]),
        .stat      (stat),
        .res_hue   (res_hue),
        .res_value (res_value),
        .res_busy  (res_busy),
        .res_dark  (res_dark)
    );

    // Output register
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {5'd0, res_dark, res_busy, res_value, res_hue};
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[sv/sla_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
module sla_div #(
    parameter int DIV_W = 32,
    parameter int DEN_W = 16,
    parameter int CNT_W = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CNT_W-1:0] count,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic [DIV_W-1:0] quotient,
    output logic [DEN_W-1:0] remainder,
    output logic             done
);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           fits;

    // One restoring step
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_W-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = count;
            quo_next = dividend;
            rem_next = '0;
            den_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - CNT_W'(1);
            rem_next  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next  = {quo_reg[DIV_W-2:0], fits};
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

[sv/sla_datapath.sv]
// Animation state, shared multiplier and divider, and per-mode colour updates.
module sla_datapath #(
    parameter int TICK_WIDTH = sla_pkg::TICK_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sla_pkg::sla_cmd_t           cmd,
    input  sla_pkg::sla_cfg_t           cfg,
    input  logic [31:0]                 in_tick,
    input  logic [sla_pkg::MODE_W-1:0]  in_mode,
    input  logic [8:0]                  in_hue,
    input  logic [7:0]                  in_value,
    output sla_pkg::sla_stat_t          stat,
    output logic [8:0]                  res_hue,
    output logic [7:0]                  res_value,
    output logic                        res_busy,
    output logic                        res_dark
);

    localparam int DIV_W = (TICK_WIDTH > sla_pkg::PROD_W) ? TICK_WIDTH : sla_pkg::PROD_W;
    localparam int CNT_W = $clog2(DIV_W + 1);

    // Architectural state
    logic [sla_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [TICK_WIDTH-1:0]      anchor_reg, anchor_next;
    logic [TICK_WIDTH-1:0]      tstart_reg, tstart_next;
    logic [8:0]                 shue_reg, shue_next;
    logic [7:0]                 sval_reg, sval_next;
    logic [8:0]                 lhue_reg, lhue_next;
    logic [7:0]                 lval_reg, lval_next;
    logic                       busy_reg, busy_next;

    // Per-word working registers
    logic [TICK_WIDTH-1:0]      now_reg, now_next;
    logic [8:0]                 rhue_reg, rhue_next;
    logic [7:0]                 rval_reg, rval_next;
    logic [15:0]                tri_reg, tri_next;

    logic [TICK_WIDTH-1:0]      now_in;
    logic [TICK_WIDTH-1:0]      elapsed_breath;
    logic [TICK_WIDTH-1:0]      elapsed_trans;
    logic [15:0]                period_eff;
    logic [15:0]                half;
    logic [15:0]                tri_raw;
    logic [15:0]                phase;
    logic [8:0]                 hue_dist;
    logic                       hue_down;

    logic [31:0]                now_ms32;
    logic [62:0]                blink_prod;
    logic                       blink_odd;

    logic [8:0]                 mul_a;
    logic [15:0]                mul_b;
    logic [sla_pkg::PROD_W-1:0] product;
    logic                       div_short;
    logic [DIV_W-1:0]           div_dividend;
    logic [sla_pkg::DEN_W-1:0]  div_divisor;
    logic [CNT_W-1:0]           div_count;
    logic [DIV_W-1:0]           div_quo;
    logic [sla_pkg::DEN_W-1:0]  div_rem;
    logic                       div_done;
    logic [8:0]                 drop;

    assign now_in = TICK_WIDTH'(in_tick);

    // Elapsed times, wrapping modulo the tick width
    assign elapsed_breath = now_reg - anchor_reg;
    assign elapsed_trans  = now_reg - tstart_reg;

    // Blink phase: halve the time, then divide by 125 through the reciprocal
    assign now_ms32   = 32'(now_reg);
    assign blink_prod = 63'(now_ms32[31:1]) * 63'(sla_pkg::BLINK_RECIP);
    assign blink_odd  = blink_prod[sla_pkg::BLINK_SHIFT];

    // Breath geometry
    assign period_eff = (cfg.period_ms < sla_pkg::MIN_PERIOD) ? sla_pkg::MIN_PERIOD
                                                              : cfg.period_ms;
    assign half  = {1'b0, period_eff[15:1]};
    assign phase = div_rem;
    always_comb
    begin
        tri_raw = (phase < half) ? phase : (period_eff - phase);
        if (tri_raw > half)
        begin
            tri_raw = half;
        end
    end

    // Distance from the start hue to the morph target hue
    assign hue_down = (shue_reg > sla_pkg::MORPH_HUE);
    assign hue_dist = hue_down ? (shue_reg - sla_pkg::MORPH_HUE)
                               : (sla_pkg::MORPH_HUE - shue_reg);

    // Operand selection for the shared multiplier and divider
    always_comb
    begin
        mul_a       = '0;
        mul_b       = '0;
        div_short   = 1'b1;
        div_divisor = half;
        unique case (cmd.div_sel)
            sla_pkg::DIV_PHASE:
            begin
                div_short   = 1'b0;
                div_divisor = period_eff;
            end
            sla_pkg::DIV_BVAL:
            begin
                mul_a = {1'b0, sla_pkg::FULL_VALUE - cfg.min_value};
                mul_b = tri_reg;
            end
            sla_pkg::DIV_BDROP:
            begin
                mul_a = cfg.hue_drop;
                mul_b = half - tri_reg;
            end
            sla_pkg::DIV_MHUE:
            begin
                mul_a       = hue_dist;
                mul_b       = elapsed_trans[15:0];
                div_divisor = cfg.morph_ms;
            end
            sla_pkg::DIV_MVAL:
            begin
                mul_a       = {1'b0, sla_pkg::FULL_VALUE - sval_reg};
                mul_b       = elapsed_trans[15:0];
                div_divisor = cfg.morph_ms;
            end
            sla_pkg::DIV_FVAL:
            begin
                mul_a       = {1'b0, sval_reg};
                mul_b       = elapsed_trans[15:0];
                div_divisor = cfg.fade_ms;
            end
            default:
            begin
                div_short = 1'b1;
            end
        endcase
    end

    assign product = sla_pkg::PROD_W'(mul_a * mul_b);

    // Short divisions enter left-aligned so only the product bits are iterated
    always_comb
    begin
        if (div_short)
        begin
            div_dividend = DIV_W'(product) << (DIV_W - sla_pkg::PROD_W);
            div_count    = CNT_W'(sla_pkg::PROD_W);
        end
        else
        begin
            div_dividend = DIV_W'(elapsed_breath);
            div_count    = CNT_W'(DIV_W);
        end
    end

    sla_div #(
        .DIV_W (DIV_W),
        .DEN_W (sla_pkg::DEN_W),
        .CNT_W (CNT_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .count     (div_count),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    assign drop = div_quo[8:0];

    // State updates: mode capture on load, colour updates on command
    always_comb
    begin
        mode_next   = mode_reg;
        anchor_next = anchor_reg;
        tstart_next = tstart_reg;
        shue_next   = shue_reg;
        sval_next   = sval_reg;
        lhue_next   = lhue_reg;
        lval_next   = lval_reg;
        busy_next   = busy_reg;
        now_next    = now_reg;
        rhue_next   = rhue_reg;
        rval_next   = rval_reg;
        tri_next    = tri_reg;

        if (cmd.load)
        begin
            now_next  = now_in;
            rhue_next = in_hue;
            rval_next = in_value;
            if (in_mode != mode_reg)
            begin
                busy_next = 1'b0;
                mode_next = in_mode;
                if (in_mode == sla_pkg::MODE_BREATHE)
                begin
                    anchor_next = now_in;
                end
                else if (in_mode == sla_pkg::MODE_FULL || in_mode == sla_pkg::MODE_FADEOUT)
                begin
                    shue_next   = lhue_reg;
                    sval_next   = lval_reg;
                    tstart_next = now_in;
                    busy_next   = 1'b1;
                end
            end
        end

        unique case (cmd.upd_sel)
            sla_pkg::UPD_OFF:
            begin
                lhue_next = '0;
                lval_next = '0;
            end
            sla_pkg::UPD_STATIC:
            begin
                lhue_next = rhue_reg;
                lval_next = rval_reg;
            end
            sla_pkg::UPD_FAULT:
            begin
                lhue_next = '0;
                lval_next = blink_odd ? sla_pkg::FULL_VALUE : 8'd0;
            end
            sla_pkg::UPD_TRI:
            begin
                tri_next = tri_raw;
            end
            sla_pkg::UPD_BVAL:
            begin
                lval_next = cfg.min_value + div_quo[7:0];
            end
            sla_pkg::UPD_BDROP:
            begin
                lhue_next = (rhue_reg > drop) ? (rhue_reg - drop) : 9'd0;
            end
            sla_pkg::UPD_MHUE:
            begin
                lhue_next = hue_down ? (shue_reg - div_quo[8:0]) : (shue_reg + div_quo[8:0]);
            end
            sla_pkg::UPD_MVAL:
            begin
                lval_next = sval_reg + div_quo[7:0];
            end
            sla_pkg::UPD_MDONE:
            begin
                lhue_next = sla_pkg::MORPH_HUE;
                lval_next = sla_pkg::FULL_VALUE;
                busy_next = 1'b0;
            end
            sla_pkg::UPD_FVAL:
            begin
                lhue_next = shue_reg;
                lval_next = sval_reg - div_quo[7:0];
            end
            sla_pkg::UPD_FDONE:
            begin
                lval_next = '0;
                busy_next = 1'b0;
            end
            default:
            begin
                lhue_next = lhue_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= sla_pkg::MODE_OFF;
            anchor_reg <= '0;
            tstart_reg <= '0;
            shue_reg   <= '0;
            sval_reg   <= '0;
            lhue_reg   <= '0;
            lval_reg   <= '0;
            busy_reg   <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            anchor_reg <= anchor_next;
            tstart_reg <= tstart_next;
            shue_reg   <= shue_next;
            sval_reg   <= sval_next;
            lhue_reg   <= lhue_next;
            lval_reg   <= lval_next;
            busy_reg   <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg  <= now_next;
        rhue_reg <= rhue_next;
        rval_reg <= rval_next;
        tri_reg  <= tri_next;
    end

    // Status back to the controller
    always_comb
    begin
        stat.mode       = mode_reg;
        stat.div_done   = div_done;
        stat.morph_over = (elapsed_trans >= TICK_WIDTH'(cfg.morph_ms));
        stat.fade_over  = (elapsed_trans >= TICK_WIDTH'(cfg.fade_ms));
    end

    assign res_hue   = lhue_reg;
    assign res_value = lval_reg;
    assign res_busy  = busy_reg;
    assign res_dark  = (lval_reg == 8'd0);

endmodule

[sv/sla_ctrl.sv]
// Sequencer that steps the datapath through one frame's divisions and updates.
module sla_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               out_free,
    input  sla_pkg::sla_stat_t stat,
    output logic               in_ready,
    output sla_pkg::sla_cmd_t  cmd
);

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE     = 4'd0;
    localparam logic [ST_W-1:0] ST_DISPATCH = 4'd1;
    localparam logic [ST_W-1:0] ST_PHASE_W  = 4'd3;
    localparam logic [ST_W-1:0] ST_TRI      = 4'd4;
    localparam logic [ST_W-1:0] ST_BVAL_W   = 4'd5;
    localparam logic [ST_W-1:0] ST_BDROP_W  = 4'd6;
    localparam logic [ST_W-1:0] ST_MHUE_W   = 4'd7;
    localparam logic [ST_W-1:0] ST_MVAL_W   = 4'd8;
    localparam logic [ST_W-1:0] ST_FVAL_W   = 4'd9;
    localparam logic [ST_W-1:0] ST_DONE     = 4'd10;

    logic [ST_W-1:0] state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        cmd.load      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.div_sel   = sla_pkg::DIV_NONE;
        cmd.upd_sel   = sla_pkg::UPD_NONE;
        cmd.out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            // Branch on the mode as it stands after the capture
            ST_DISPATCH:
            begin
                unique case (stat.mode)
                    sla_pkg::MODE_OFF:
                    begin
                        cmd.upd_sel = sla_pkg::UPD_OFF;
                        state_next  = ST_DONE;
                    end
                    sla_pkg::MODE_STATIC:
                    begin
                        cmd.upd_sel = sla_pkg::UPD_STATIC;
                        state_next  = ST_DONE;
                    end
                    sla_pkg::MODE_FAULT:
                    begin
                        cmd.upd_sel = sla_pkg::UPD_FAULT;
                        state_next  = ST_DONE;
                    end
                    sla_pkg::MODE_BREATHE:
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = sla_pkg::DIV_PHASE;
                        state_next    = ST_PHASE_W;
                    end
                    sla_pkg::MODE_FULL:
                    begin
                        if (stat.morph_over)
                        begin
                            cmd.upd_sel = sla_pkg::UPD_MDONE;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            cmd.div_start = 1'b1;
                            cmd.div_sel   = sla_pkg::DIV_MHUE;
                            state_next    = ST_MHUE_W;
                        end
                    end
                    sla_pkg::MODE_FADEOUT:
                    begin
                        if (stat.fade_over)
                        begin
                            cmd.upd_sel = sla_pkg::UPD_FDONE;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            cmd.div_start = 1'b1;
                            cmd.div_sel   = sla_pkg::DIV_FVAL;
                            state_next    = ST_FVAL_W;
                        end
                    end
                    // Unknown modes hold the shown colour
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_PHASE_W:
            begin
                if (stat.div_done)
                begin
                    cmd.upd_sel = sla_pkg::UPD_TRI;
                    state_next  = ST_TRI;
                end
            end
            ST_TRI:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = sla_pkg::DIV_BVAL;
                state_next    = ST_BVAL_W;
            end
            ST_BVAL_W:
            begin
                if (stat.div_done)
                begin
                    cmd.upd_sel   = sla_pkg::UPD_BVAL;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = sla_pkg::DIV_BDROP;
                    state_next    = ST_BDROP_W;
                end
            end
            ST_BDROP_W:
            begin
                if (stat.div_done)
                begin
                    cmd.upd_sel = sla_pkg::UPD_BDROP;
                    state_next  = ST_DONE;
                end
            end
            ST_MHUE_W:
            begin
                if (stat.div_done)
                begin
                    cmd.upd_sel   = sla_pkg::UPD_MHUE;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = sla_pkg::DIV_MVAL;
                    state_next    = ST_MVAL_W;
                end
            end
            ST_MVAL_W:
            begin
                if (stat.div_done)
                begin
                    cmd.upd_sel = sla_pkg::UPD_MVAL;
                    state_next  = ST_DONE;
                end
            end
            ST_FVAL_W:
            begin
                if (stat.div_done)
                begin
                    cmd.upd_sel = sla_pkg::UPD_FVAL;
                    state_next  = ST_DONE;
                end
            end
            // Hand the word over once the output register is free
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[tb/sla_frame_checker.sv]
// Frame checker for the status LED animation engine: predicts each shown word and compares.
module sla_frame_checker
    import sla_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [55:0] s_tdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [8:0] hue;
        logic [7:0] val;
        logic       busy;
        logic       dark;
    } shown_t;

    // Register copies
    logic [15:0] period_ms;
    logic [8:0]  hue_drop;
    logic [7:0]  min_val;
    logic [15:0] morph_ms;
    logic [15:0] fade_ms;

    // Animation state
    logic [2:0]  cur_mode;
    logic [31:0] anchor;
    logic [31:0] ramp_start;
    logic [8:0]  from_hue;
    logic [7:0]  from_val;
    logic [8:0]  lit_hue;
    logic [7:0]  lit_val;
    logic        in_ramp;

    shown_t due_shown[$];
    shown_t want;
    shown_t got_word;

    task automatic report_mismatch(input string what, input longint unsigned exp_v,
                                   input longint unsigned got_v);
        $display("%0t mismatch on %s: expected %0d, got %0d", $time, what, exp_v, got_v);
        fail_count++;
    endtask

    // a + (b - a) * p / dur, truncated toward zero
    function automatic logic [31:0] ramp(input longint signed a, input longint signed b,
                                         input longint signed p, input longint signed dur);
        longint signed r;
        r = a + ((b - a) * p) / dur;
        return r[31:0];
    endfunction

    task automatic predict_frame(input logic [31:0] now, input logic [2:0] req,
                                 input logic [8:0] rhue, input logic [7:0] rval,
                                 output shown_t res);
        longint unsigned per, half, phase, tri_v, dip, lvl;
        logic [31:0] dt;
        logic [31:0] step;
        // mode change: drop busy, then capture what the new mode starts from
        if (req != cur_mode) begin
            in_ramp = 1'b0;
            if (req == MODE_BREATHE) begin
                anchor = now;
            end
            else if (req == MODE_FULL || req == MODE_FADEOUT) begin
                from_hue   = lit_hue;
                from_val   = lit_val;
                ramp_start = now;
                in_ramp    = 1'b1;
            end
            cur_mode = req;
        end
        dt = now - ramp_start;
        case (cur_mode)
            MODE_OFF:
            begin
                lit_hue = '0;
                lit_val = '0;
            end
            MODE_STATIC:
            begin
                lit_hue = rhue;
                lit_val = rval;
            end
            MODE_BREATHE:
            begin
                per   = (period_ms < 16'd2) ? 64'd2 : 64'(period_ms);
                half  = per / 2;
                step  = now - anchor;
                phase = 64'(step) % per;
                tri_v = (phase < half) ? phase : per - phase;
                if (tri_v > half)
                    tri_v = half;
                dip     = (64'(hue_drop) * (half - tri_v)) / half;
                lvl     = 64'(min_val) + ((64'd255 - 64'(min_val)) * tri_v) / half;
                lit_val = lvl[7:0];
                lit_hue = (64'(rhue) > dip) ? 9'(64'(rhue) - dip) : 9'd0;
            end
            MODE_FULL:
            begin
                if (dt >= 32'(morph_ms)) begin
                    lit_hue = 9'd120;
                    lit_val = 8'd255;
                    in_ramp = 1'b0;
                end
                else begin
                    step    = ramp(from_hue, 120, dt, morph_ms);
                    lit_hue = step[8:0];
                    step    = ramp(from_val, 255, dt, morph_ms);
                    lit_val = step[7:0];
                end
            end
            MODE_FADEOUT:
            begin
                if (dt >= 32'(fade_ms)) begin
                    lit_val = '0;
                    in_ramp = 1'b0;
                end
                else begin
                    lit_hue = from_hue;
                    step    = ramp(from_val, 0, dt, fade_ms);
                    lit_val = step[7:0];
                end
            end
            MODE_FAULT:
            begin
                step    = now / 32'd250;
                lit_hue = '0;
                lit_val = step[0] ? 8'd255 : 8'd0;
            end
            default:
            begin
                // unknown mode: hold the last colour
            end
        endcase
        res.hue  = lit_hue;
        res.val  = lit_val;
        res.busy = in_ramp;
        res.dark = (lit_val == 8'd0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            period_ms  <= RST_BREATH_PERIOD;
            hue_drop   <= RST_BREATH_DROP;
            min_val    <= RST_BREATH_MIN;
            morph_ms   <= RST_MORPH_DUR;
            fade_ms    <= RST_FADE_DUR;
            cur_mode   <= MODE_OFF;
            anchor     <= '0;
            ramp_start <= '0;
            from_hue   <= '0;
            from_val   <= '0;
            lit_hue    <= '0;
            lit_val    <= '0;
            in_ramp    <= 1'b0;
            fail_count <= 0;
            pending    <= 0;
            due_shown.delete();
        end
        else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_BREATH_PERIOD: period_ms = pwdata[15:0];
                    REG_BREATH_DROP:   hue_drop  = pwdata[8:0];
                    REG_BREATH_MIN:    min_val   = pwdata[7:0];
                    REG_MORPH_DUR:     morph_ms  = pwdata[15:0];
                    REG_FADE_DUR:      fade_ms   = pwdata[15:0];
                    default:           ;
                endcase
            end
            // frame word in: predict what it shows
            if (s_tvalid && s_tready) begin
                predict_frame(s_tdata[31:0], s_tdata[34:32], s_tdata[43:35], s_tdata[51:44],
                              want);
                due_shown.push_back(want);
            end
            // shown word out: compare with the oldest prediction
            if (m_tvalid && m_tready) begin
                got_word = {m_tdata[8:0], m_tdata[16:9], m_tdata[17], m_tdata[18]};
                if (due_shown.size() == 0) begin
                    report_mismatch("word with nothing due", 0, m_tdata);
                end
                else begin
                    want = due_shown.pop_front();
                    if (got_word.hue != want.hue)
                        report_mismatch("shown_hue", want.hue, got_word.hue);
                    if (got_word.val != want.val)
                        report_mismatch("shown_value", want.val, got_word.val);
                    if (got_word.busy != want.busy)
                        report_mismatch("busy_res", want.busy, got_word.busy);
                    if (got_word.dark != want.dark)
                        report_mismatch("dark", want.dark, got_word.dark);
                    if (m_tdata[23:19] != '0)
                        report_mismatch("tdata padding", 0, m_tdata[23:19]);
                end
            end
            pending <= due_shown.size();
        end
    end

endmodule

[tb/status_led_animation_engine_tb.sv]
// Testbench top for the status LED animation engine: clock, reset, stimulus and verdict.
module status_led_animation_engine_tb;
    import sla_pkg::*;

    // Codes outside the defined modes
    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    typedef enum logic [1:0] {RDY_OPEN, RDY_COIN, RDY_SPELLS, RDY_SPARSE} rdy_style_t;

    logic        clk;
    logic        rst_n;
    logic [55:0] s_tdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;

    int          burst_left;
    logic [31:0] tbase;
    int          cfg_period;
    int          cfg_morph;
    int          cfg_fade;

    rdy_style_t  rdy_style;
    logic [15:0] rdy_cnt;
    int          rdy_hold;

    status_led_animation_engine uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    sla_frame_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tdata    (s_tdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop
    initial
    begin
        #8000000;
        $display("Test completed with failures");
        $finish;
    end

    // Receiver: picks a new stall pattern each time the low nine bits of rdy_cnt come round to zero
    always @(posedge clk)
    begin
        rdy_cnt <= rdy_cnt + 16'd1;
        if (rdy_cnt[8:0] == 9'd0)
            rdy_style <= rdy_style_t'($urandom_range(0, 3));
        if (rdy_hold != 0)
            rdy_hold <= rdy_hold - 1;
        case (rdy_style)
            RDY_OPEN:   m_tready <= 1'b1;
            RDY_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RDY_SPELLS:
            begin
                if (rdy_hold == 0) begin
                    m_tready <= ~m_tready;
                    rdy_hold <= $urandom_range(1, 60);
                end
            end
            default:    m_tready <= (rdy_cnt[2:0] == 3'd5);
        endcase
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_BREATH_PERIOD: cfg_period = data[15:0];
            REG_MORPH_DUR:     cfg_morph  = data[15:0];
            REG_FADE_DUR:      cfg_fade   = data[15:0];
            default:           ;
        endcase
    endtask

    task automatic set_regs(input logic [31:0] per, input logic [31:0] drop,
                            input logic [31:0] minv, input logic [31:0] morph,
                            input logic [31:0] fade);
        write_reg(REG_BREATH_PERIOD, per);
        write_reg(REG_BREATH_DROP, drop);
        write_reg(REG_BREATH_MIN, minv);
        write_reg(REG_MORPH_DUR, morph);
        write_reg(REG_FADE_DUR, fade);
    endtask

    // Offer one frame word; settle drains every due word before returning
    task automatic send_frame(input logic [31:0] tk, input logic [2:0] md,
                              input logic [8:0] hu, input logic [7:0] vl, input bit settle);
        s_tdata  <= {4'b0, vl, hu, md, tk};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        burst_left--;
        if (burst_left <= 0 || settle) begin
            s_tvalid <= 1'b0;
            if (settle) begin
                @(posedge clk);
                while (pending != 0) @(posedge clk);
                repeat (8) @(posedge clk);
            end
            else begin
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Scenes: a mode held for a few frames with time moving at a pace that suits it
    task automatic run_phase(input int n);
        int sent;
        int hold;
        int span;
        int k;
        logic [2:0] md;
        logic [8:0] hu;
        sent = 0;
        while (sent < n) begin
            case ($urandom_range(0, 9))
                0:       md = MODE_OFF;
                1, 2:    md = MODE_BREATHE;
                3, 4:    md = MODE_FULL;
                5:       md = MODE_FAULT;
                6:       md = MODE_STATIC;
                7, 8:    md = MODE_FADEOUT;
                default: md = $urandom_range(0, 1) ? MODE_SPARE_LO : MODE_SPARE_HI;
            endcase
            hu   = ($urandom_range(0, 5) == 0) ? 9'($urandom_range(360, 511))
                                               : 9'($urandom_range(0, 359));
            hold = $urandom_range(1, 10);
            case (md)
                MODE_BREATHE: span = cfg_period;
                MODE_FULL:    span = cfg_morph;
                MODE_FADEOUT: span = cfg_fade;
                MODE_FAULT:   span = 250;
                default:      span = 100;
            endcase
            for (k = 0; k < hold && sent < n; k++) begin
                if ($urandom_range(0, 31) == 0)
                    tbase = $urandom;
                else if ($urandom_range(0, 47) == 0)
                    tbase = 32'hFFFF_FFFF - $urandom_range(0, 2 * span + 2);
                else
                    tbase = tbase + $urandom_range(0, span / 3 + 1);
                sent++;
                if ($urandom_range(0, 11) == 0)
                    send_frame($urandom, 3'($urandom), 9'($urandom), 8'($urandom), sent == n);
                else
                    send_frame(tbase, md, hu, 8'($urandom),
                               sent == n || $urandom_range(0, 99) == 0);
            end
        end
    endtask

    initial
    begin
        int ph;
        rst_n      = 1'b0;
        s_tdata    = '0;
        s_tvalid   = 1'b0;
        m_tready   = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        burst_left = 1;
        tbase      = '0;
        cfg_period = RST_BREATH_PERIOD;
        cfg_morph  = RST_MORPH_DUR;
        cfg_fade   = RST_FADE_DUR;
        rdy_style  = RDY_OPEN;
        rdy_cnt    = '0;
        rdy_hold   = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames on reset register values
        send_frame(32'd0,          MODE_OFF,      9'd511, 8'd255, 0);
        send_frame(32'hFFFF_FFFF,  MODE_STATIC,   9'd359, 8'd255, 0);
        send_frame(32'hFFFF_FFFF,  MODE_STATIC,   9'd511, 8'd0,   0);
        // breathe: trough, quarter, peak, then a hue dip below zero
        send_frame(32'd1000,       MODE_BREATHE,  9'd200, 8'd0,   0);
        send_frame(32'd1500,       MODE_BREATHE,  9'd200, 8'd0,   0);
        send_frame(32'd2000,       MODE_BREATHE,  9'd200, 8'd0,   0);
        send_frame(32'd2999,       MODE_BREATHE,  9'd10,  8'd0,   0);
        // morph from the breathe colour, re-requested while running, then done
        send_frame(32'd5000,       MODE_FULL,     9'd0,   8'd0,   0);
        send_frame(32'd5500,       MODE_FULL,     9'd0,   8'd0,   0);
        send_frame(32'd5999,       MODE_FULL,     9'd0,   8'd0,   0);
        send_frame(32'd6000,       MODE_FULL,     9'd0,   8'd0,   0);
        // fade to dark, hue held once over
        send_frame(32'd6100,       MODE_FADEOUT,  9'd0,   8'd0,   0);
        send_frame(32'd6350,       MODE_FADEOUT,  9'd0,   8'd0,   0);
        send_frame(32'd6600,       MODE_FADEOUT,  9'd0,   8'd0,   0);
        // fault blink edges
        send_frame(32'd249,        MODE_FAULT,    9'd0,   8'd0,   0);
        send_frame(32'd250,        MODE_FAULT,    9'd0,   8'd0,   0);
        send_frame(32'd499,        MODE_FAULT,    9'd0,   8'd0,   0);
        send_frame(32'd500,        MODE_FAULT,    9'd0,   8'd0,   0);
        // unknown modes clear busy and hold the colour
        send_frame(32'd7000,       MODE_FULL,     9'd0,   8'd0,   0);
        send_frame(32'd7100,       MODE_SPARE_LO, 9'd77,  8'd99,  0);
        send_frame(32'd7200,       MODE_SPARE_HI, 9'd88,  8'd11,  0);
        // time wrap inside a morph and a breath
        send_frame(32'hFFFF_FF00,  MODE_FULL,     9'd0,   8'd0,   0);
        send_frame(32'h0000_0100,  MODE_FULL,     9'd0,   8'd0,   0);
        send_frame(32'hFFFF_FFF0,  MODE_BREATHE,  9'd359, 8'd0,   0);
        send_frame(32'h0000_0400,  MODE_BREATHE,  9'd359, 8'd0,   1);

        // Extreme settings: short periods, zero and one-ms durations, long ones
        set_regs(32'd0, 32'd511, 32'd0, 32'd0, 32'd0);
        run_phase(158);
        set_regs(32'd1, 32'd0, 32'd255, 32'd1, 32'd1);
        run_phase(158);
        set_regs(32'd65535, 32'd359, 32'd128, 32'd65535, 32'd65535);
        run_phase(158);
        set_regs(32'd3, 32'd359, 32'd255, 32'd2, 32'd7);
        run_phase(158);
        // Random settings, upper bits of the bus word set too
        for (ph = 0; ph < 5; ph++) begin
            set_regs($urandom, $urandom, $urandom, $urandom, $urandom);
            run_phase(158);
        end

        repeat (64) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[files.f]
sv/sla_pkg.sv
sv/sla_div.sv
sv/sla_datapath.sv
sv/sla_ctrl.sv
sv/status_led_animation_engine.sv
tb/sla_frame_checker.sv
tb/status_led_animation_engine_tb.sv
